[design/haud_pkg.sv]
package haud_pkg;

  typedef struct packed {
    logic [7:0] unit_byte;
    logic       unit_end;
  } haud_in_t;

  typedef struct packed {
    logic        starts_access_unit;
    logic        key_picture;
    logic [4:0]  unit_kind;
    logic [1:0]  reference_level;
    logic [13:0] picture_width;
    logic [13:0] picture_height;
  } haud_out_t;

  localparam logic [4:0] KIND_SLICE = 5'd1;
  localparam logic [4:0] KIND_IDR   = 5'd5;
  localparam logic [4:0] KIND_SPS   = 5'd7;
  localparam logic [4:0] KIND_PPS   = 5'd8;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] S_PROFILE  = 5'd1;
  localparam logic [4:0] S_SKIP16   = 5'd2;
  localparam logic [4:0] S_SPSID    = 5'd3;
  localparam logic [4:0] S_CHROMA   = 5'd4;
  localparam logic [4:0] S_SEPCOL   = 5'd5;
  localparam logic [4:0] S_BDL      = 5'd6;
  localparam logic [4:0] S_BDC      = 5'd7;
  localparam logic [4:0] S_BYPASS   = 5'd8;
  localparam logic [4:0] S_SMP      = 5'd9;
  localparam logic [4:0] S_SLP      = 5'd10;
  localparam logic [4:0] S_DELTA    = 5'd11;
  localparam logic [4:0] S_LOG2FN   = 5'd12;
  localparam logic [4:0] S_POCTYPE  = 5'd13;
  localparam logic [4:0] S_LOG2POC  = 5'd14;
  localparam logic [4:0] S_DPOAZ    = 5'd15;
  localparam logic [4:0] S_OFFNR    = 5'd16;
  localparam logic [4:0] S_OFFTB    = 5'd17;
  localparam logic [4:0] S_NCYCLE   = 5'd18;
  localparam logic [4:0] S_CYCOFF   = 5'd19;
  localparam logic [4:0] S_NUMREF   = 5'd20;
  localparam logic [4:0] S_GAPS     = 5'd21;
  localparam logic [4:0] S_WIDTH    = 5'd22;
  localparam logic [4:0] S_HEIGHT   = 5'd23;
  localparam logic [4:0] S_FMO      = 5'd24;
  localparam logic [4:0] L_FIRSTMB  = 5'd25;
  localparam logic [4:0] L_TYPE     = 5'd26;
  localparam logic [4:0] L_PPSID    = 5'd27;
  localparam logic [4:0] L_FRAMENUM = 5'd28;
  localparam logic [4:0] L_IDR      = 5'd29;
  localparam logic [4:0] L_POC      = 5'd30;

  // fixed field width of a phase, 0 for exp-golomb or variable
  function automatic logic [4:0] fixed_width(input logic [4:0] p);
    case (p)
      S_PROFILE: fixed_width = 5'd8;
      S_SKIP16:  fixed_width = 5'd16;
      S_SEPCOL, S_BYPASS, S_SMP, S_SLP, S_DPOAZ, S_GAPS: fixed_width = 5'd1;
      default:   fixed_width = 5'd0;
    endcase
  endfunction

endpackage

[design/haud_bit_parser.sv]
module haud_bit_parser
  import haud_pkg::*;
#(
  parameter int MAX_CODE_BITS  = 32,
  parameter int MAX_POC_CYCLE  = 256,
  parameter int MAX_DIM_PIXELS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [4:0]  start_phase,
  input  logic [4:0]  kind,
  input  logic        unit_begin,
  input  logic        bit_valid,
  input  logic        bit_value,
  output logic        idle,
  output logic        key_flag,
  output logic        start_flag,
  output logic [13:0] stored_width,
  output logic [13:0] stored_height
);

  localparam int DIM_CAP_I = (MAX_DIM_PIXELS > 16383) ? 16383 : MAX_DIM_PIXELS;
  localparam logic [13:0] DIM_CAP = 14'(DIM_CAP_I);
  localparam int CW = MAX_CODE_BITS + 1;
  localparam logic [CW-1:0] SAT_CODE = {1'b0, {MAX_CODE_BITS{1'b1}}};

  logic [4:0]    phase;
  logic [CW-1:0] acc;
  logic [5:0]    lzc;
  logic [8:0]    loop_counter;
  logic [7:0]    scale_running;
  logic [7:0]    profile_value;
  logic [4:0]    frame_num_bits;
  logic [2:0]    poc_mode;
  logic [4:0]    poc_lsb_bits;
  logic          high_seen;
  logic [16:0]   last_fn, last_idr, last_poc;
  logic [14:0]   hmap;
  logic          prev_idr;
  logic          done;
  logic [CW-1:0] fval;
  logic [4:0]    fw;
  logic [CW-1:0] acc_sh;

  // one decoded value per step, then dispatch (one bit per cycle while bit_valid is high)
  always_comb begin
    fw = fixed_width(phase);
    if (phase == L_FRAMENUM) fw = frame_num_bits;
    if (phase == L_POC) fw = poc_lsb_bits;
    acc_sh = {acc[CW-2:0], bit_value};
    done = 1'b0;
    fval = acc_sh;
    if (fw != 5'd0) begin
      done = (lzc + 6'd1) >= {1'b0, fw};
    end else if (acc == '0) begin
      if (!bit_value) begin
        done = (lzc + 6'd1) >= 6'(MAX_CODE_BITS);
        fval = SAT_CODE;
      end else if (lzc == 6'd0) begin
        done = 1'b1;
        fval = '0;
      end
    end else begin
      done = lzc == 6'd1;
      fval = acc_sh - 1'b1;
    end
  end

  assign idle = phase == PH_IDLE;

  function automatic logic [4:0] cap_len(input logic [CW-1:0] v);
    cap_len = (v > 12) ? 5'd16 : 5'(v + 4);
  endfunction

  always_ff @(posedge clk) begin
    logic [4:0]    np;
    logic [8:0]    i9;
    logic [5:0]    j;
    logic [7:0]    sr;
    logic [16:0]   v17;
    logic [16:0]   wsum;
    logic [19:0]   hh;
    if (rst) begin
      phase <= PH_IDLE; acc <= '0; lzc <= '0; loop_counter <= '0;
      scale_running <= 8'd8; profile_value <= '0; frame_num_bits <= '0;
      poc_mode <= 3'd7; poc_lsb_bits <= '0; high_seen <= 1'b0;
      stored_width <= '0; stored_height <= '0; last_fn <= '1; last_idr <= '1;
      last_poc <= '1; prev_idr <= 1'b0; key_flag <= 1'b0; start_flag <= 1'b0;
      hmap <= '0;
    end else if (start) begin
      start_flag <= (kind == KIND_SPS) || (kind == KIND_PPS);
      np = start_phase;
      if (np == L_FRAMENUM && frame_num_bits == 0) np = PH_IDLE;
      phase <= np; acc <= '0; lzc <= '0;
    end else if (unit_begin) begin
      // kind of the finished unit, for the next idr comparison
      prev_idr <= kind == KIND_IDR;
    end else if (bit_valid && phase != PH_IDLE) begin
      np = PH_IDLE;
      v17 = (fval > 33'h1FFFE) ? 17'h1FFFE : fval[16:0];
      if (phase == S_FMO) begin
        hh = {hmap, 5'd0};
        if (bit_value) hh = {1'b0, hh[19:1]};
        stored_height <= (hh > 20'(DIM_CAP)) ? DIM_CAP : hh[13:0];
        phase <= PH_IDLE; acc <= '0; lzc <= '0;
      end else if (!done) begin
        if (fw != 0) begin
          acc <= acc_sh; lzc <= lzc + 6'd1;
        end else if (acc == '0) begin
          if (!bit_value) lzc <= lzc + 6'd1; else acc <= CW'(1);
        end else begin
          acc <= acc_sh; lzc <= lzc - 6'd1;
        end
      end else begin
        case (phase)
          S_PROFILE: begin profile_value <= fval[7:0]; np = S_SKIP16; end
          S_SKIP16:  np = S_SPSID;
          S_SPSID: begin
            if (profile_value >= 8'd100) begin high_seen <= 1'b1; np = S_CHROMA; end
            else np = S_LOG2FN;
          end
          S_CHROMA:  np = (fval == 3) ? S_SEPCOL : S_BDL;
          S_SEPCOL:  np = S_BDL;
          S_BDL:     np = S_BDC;
          S_BDC:     np = S_BYPASS;
          S_BYPASS:  np = S_SMP;
          S_SMP: begin
            if (fval != 0) begin loop_counter <= '0; np = S_SLP; end else np = S_LOG2FN;
          end
          S_SLP: begin
            if (fval != 0) begin
              scale_running <= 8'd8; loop_counter <= loop_counter & 9'h1C0; np = S_DELTA;
            end else begin
              i9 = {6'd0, loop_counter[8:6]} + 9'd1;
              if (i9 >= 9'd8) np = S_LOG2FN;
              else begin loop_counter <= {i9[2:0], 6'd0}; np = S_SLP; end
            end
          end
          S_DELTA: begin
            sr = fval[0] ? scale_running + fval[8:1] + 8'd1 : scale_running - fval[8:1];
            scale_running <= sr;
            j = loop_counter[5:0] + 6'd1;
            if (sr == 0 || (loop_counter[8:6] < 3'd6 ? j >= 6'd16 : j == 6'd0)) begin
              i9 = {6'd0, loop_counter[8:6]} + 9'd1;
              if (i9 >= 9'd8) np = S_LOG2FN;
              else begin loop_counter <= {i9[2:0], 6'd0}; np = S_SLP; end
            end else begin
              loop_counter <= {loop_counter[8:6], j}; np = S_DELTA;
            end
          end
          S_LOG2FN:  begin frame_num_bits <= cap_len(fval); np = S_POCTYPE; end
          S_POCTYPE: begin
            poc_mode <= (fval > 6) ? 3'd6 : fval[2:0];
            if (fval == 0) np = S_LOG2POC;
            else if (fval == 1) np = S_DPOAZ;
            else np = S_NUMREF;
          end
          S_LOG2POC: begin poc_lsb_bits <= cap_len(fval); np = S_NUMREF; end
          S_DPOAZ:   np = S_OFFNR;
          S_OFFNR:   np = S_OFFTB;
          S_OFFTB:   np = S_NCYCLE;
          S_NCYCLE: begin
            i9 = (fval > MAX_POC_CYCLE) ? 9'(MAX_POC_CYCLE) : fval[8:0];
            loop_counter <= i9;
            np = (i9 != 0) ? S_CYCOFF : S_NUMREF;
          end
          S_CYCOFF: begin
            loop_counter <= loop_counter - 9'd1;
            np = (loop_counter != 9'd1) ? S_CYCOFF : S_NUMREF;
          end
          S_NUMREF:  np = S_GAPS;
          S_GAPS:    np = S_WIDTH;
          S_WIDTH: begin
            wsum = (fval >= 33'd1024) ? 17'h1FFFF : {2'b00, fval[9:0] + 11'd1, 4'd0};
            stored_width <= (wsum > 17'(DIM_CAP)) ? DIM_CAP : wsum[13:0];
            np = S_HEIGHT;
          end
          S_HEIGHT: begin
            hmap <= (fval >= 33'd1024) ? 15'h7FFF : 15'(fval[9:0] + 11'd1);
            np = S_FMO;
          end
          L_FIRSTMB: np = L_TYPE;
          L_TYPE: begin
            if (fval == 2 || fval == 7 || fval == 4 || fval == 9)
              key_flag <= (kind == KIND_IDR) || (high_seen && kind == KIND_SLICE);
            else if (fval <= 9) key_flag <= 1'b0;
            np = L_PPSID;
          end
          L_PPSID:   np = L_FRAMENUM;
          L_FRAMENUM: begin
            if (fval[16:0] != last_fn) start_flag <= 1'b1;
            last_fn <= fval[16:0];
            if (kind == KIND_IDR) np = L_IDR;
            else if (poc_mode == 0) np = L_POC;
          end
          L_IDR: begin
            if (prev_idr && last_idr != v17) start_flag <= 1'b1;
            last_idr <= v17;
            if (poc_mode == 0) np = L_POC;
          end
          L_POC: begin
            if (fval[16:0] != last_poc) start_flag <= 1'b1;
            last_poc <= fval[16:0];
          end
          default: np = PH_IDLE;
        endcase
        // zero-width fields complete at once
        if (np == L_FRAMENUM && frame_num_bits == 0) begin
          if (last_fn != 0) start_flag <= 1'b1;
          last_fn <= '0;
          np = (kind == KIND_IDR) ? L_IDR : (poc_mode == 0) ? L_POC : PH_IDLE;
        end
        if (np == L_POC && poc_lsb_bits == 0) begin
          if (last_poc != 0) start_flag <= 1'b1;
          last_poc <= '0;
          np = PH_IDLE;
        end
        phase <= np; acc <= '0; lzc <= '0;
      end
    end
  end

endmodule

[design/h264_access_unit_detector_unit.sv]
// h264 access unit detector
// in:  one nal unit byte per item (start code removed, header byte first),
//      unit_end marks the last byte of the unit
// out: one item per finished unit: access unit start, key flag, unit kind,
//      ref level and stored frame size from the last sps
// each payload byte shifts through a bit register into the serial field
// parser, one bit per cycle: a payload byte is accepted, then shifted out
// bit by bit while the input stalls; a header or dropped emulation byte is only accepted
// on unit_end the parser is clocked with zero bits until it goes idle,
// then ST_DONE loads the output register once it is free; the drain runs
// longest when a cut-short poc cycle loop or scaling list reads every
// missing code as 32 zero bits
// the result sits in an output register, so the next unit's bytes are
// taken while it waits; a stalled receiver holds the block only once the
// next result is ready as well
// reset (rst, synchronous) clears all stored sps and slice state
module h264_access_unit_detector_unit
  import haud_pkg::*;
#(
  parameter int MAX_CODE_BITS  = 32,
  parameter int MAX_POC_CYCLE  = 256,
  parameter int MAX_DIM_PIXELS = 8192
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  haud_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output haud_out_t out_data
);

  localparam logic [1:0] ST_TAKE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [7:0] shreg;
  logic [3:0] bit_cnt;
  logic       last;
  logic       header_pending;
  logic [1:0] zero_run;
  logic [4:0] kind;
  logic [1:0] ref_level;

  logic        start, unit_begin, bit_valid, bit_value, idle;
  logic [4:0]  start_phase;
  logic        key_flag, start_flag;
  logic [13:0] width, height;
  logic        take;
  logic        out_free;

  assign in_stall = state != ST_TAKE;
  assign take = in_valid && !in_stall;
  // output register empty or being emptied this cycle
  assign out_free = !out_valid || !out_stall;

  // header byte starts the parser in the phase for its kind
  always_comb begin
    if (in_data.unit_byte[4:0] == KIND_SPS) start_phase = S_PROFILE;
    else if (in_data.unit_byte[4:0] >= KIND_SLICE && in_data.unit_byte[4:0] <= KIND_IDR)
      start_phase = L_FIRSTMB;
    else start_phase = PH_IDLE;
  end

  assign start      = take && header_pending;
  // finished unit: parser records its kind for the next idr check
  assign unit_begin = state == ST_DONE;
  assign bit_valid  = state == ST_SHIFT || state == ST_DRAIN;
  assign bit_value  = state == ST_SHIFT ? shreg[7] : 1'b0;

  haud_bit_parser #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .MAX_POC_CYCLE(MAX_POC_CYCLE),
    .MAX_DIM_PIXELS(MAX_DIM_PIXELS)
  ) u_parser (
    .clk(clk), .rst(rst), .start(start), .start_phase(start_phase),
    .kind(start ? in_data.unit_byte[4:0] : kind), .unit_begin(unit_begin),
    .bit_valid(bit_valid), .bit_value(bit_value), .idle(idle),
    .key_flag(key_flag), .start_flag(start_flag), .stored_width(width),
    .stored_height(height)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE; header_pending <= 1'b1; zero_run <= '0;
      kind <= '0; ref_level <= '0; out_valid <= 1'b0; bit_cnt <= '0; last <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_TAKE: begin
          if (take) begin
            last <= in_data.unit_end;
            if (header_pending) begin
              header_pending <= 1'b0; zero_run <= '0;
              kind <= in_data.unit_byte[4:0]; ref_level <= in_data.unit_byte[6:5];
              state <= in_data.unit_end ? ST_DRAIN : ST_TAKE;
            end else if (zero_run == 2'd2 && in_data.unit_byte == 8'h03) begin
              // emulation prevention byte dropped
              zero_run <= '0;
              state <= in_data.unit_end ? ST_DRAIN : ST_TAKE;
            end else begin
              shreg <= in_data.unit_byte; bit_cnt <= 4'd8; state <= ST_SHIFT;
              if (in_data.unit_byte == 8'd0) zero_run <= (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
              else zero_run <= '0;
            end
          end
        end
        ST_SHIFT: begin
          shreg <= {shreg[6:0], 1'b0};
          bit_cnt <= bit_cnt - 4'd1;
          if (bit_cnt == 4'd1) state <= last ? ST_DRAIN : ST_TAKE;
        end
        ST_DRAIN: begin
          if (idle) state <= ST_DONE;
        end
        ST_DONE: begin
          // wait here until the previous item has left the output register
          if (out_free) begin
            out_data.starts_access_unit <= start_flag;
            out_data.key_picture <= key_flag;
            out_data.unit_kind <= kind;
            out_data.reference_level <= ref_level;
            out_data.picture_width <= width;
            out_data.picture_height <= height;
            header_pending <= 1'b1; zero_run <= '0;
            state <= ST_TAKE;
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end

endmodule

[tb/sv/h264_access_unit_detector_unit_tb.sv]
module h264_access_unit_detector_unit_tb;
  import haud_pkg::*;

  localparam int CODE_BITS = 32;
  localparam int POC_CYCLE_CAP = 256;
  localparam int DIM_CAP = 8192;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int ITEM_TARGET = 1050;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  haud_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  haud_out_t out_data;

  h264_access_unit_detector_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // expected unit summaries, oldest first
  haud_out_t unit_summary_q[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int tx_idle_pct = 38;
  int rx_idle_pct = 38;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // parser shadow state
  // ---------------------------------------------------------------------
  int          zrun;
  bit          hdr_pending;
  logic [4:0]  cur_kind;
  logic [1:0]  cur_ref;
  logic [4:0]  phase;
  logic [63:0] acc;
  int          lz;
  logic [8:0]  loop_cnt;
  logic [7:0]  scale;
  logic [7:0]  profile;
  int          fn_bits, poc_mode, poc_bits;
  bit          high_seen;
  int          width_px, height_px;
  logic [31:0] last_fn, last_idr, last_poc;
  int          prev_kind;
  bit          key, start;

  function automatic void parser_reset();
    zrun = 0; hdr_pending = 1; cur_kind = 0; cur_ref = 0; phase = PH_IDLE;
    acc = 0; lz = 0; loop_cnt = 0; scale = 8; profile = 0; fn_bits = 0;
    poc_mode = 7; poc_bits = 0; high_seen = 0; width_px = 0; height_px = 0;
    last_fn = 32'h1FFFF; last_idr = 32'h1FFFF; last_poc = 32'h1FFFF;
    prev_kind = 63; key = 0; start = 0;
  endfunction

  // bit width of a fixed field, -1 for an exp-golomb code
  function automatic int phase_width(input logic [4:0] p);
    case (p)
      S_PROFILE: return 8;
      S_SKIP16: return 16;
      S_SEPCOL, S_BYPASS, S_SMP, S_SLP, S_DPOAZ, S_GAPS, S_FMO: return 1;
      L_FRAMENUM: return fn_bits;
      L_POC: return poc_bits;
      default: return -1;
    endcase
  endfunction

  function automatic void enter(input logic [4:0] p);
    phase = p; acc = 0; lz = 0;
  endfunction

  function automatic int dim_cap(input logic [63:0] v);
    return (v > DIM_CAP) ? DIM_CAP : int'(v);
  endfunction

  function automatic int len_cap(input logic [63:0] v);
    return (v + 4 > 16) ? 16 : int'(v + 4);
  endfunction

  function automatic void next_scaling_list();
    logic [3:0] idx;
    idx = loop_cnt[8:6] + 1;
    if (idx >= 8) enter(S_LOG2FN);
    else begin
      loop_cnt = {idx[2:0], 6'd0};
      enter(S_SLP);
    end
  endfunction

  function automatic void field_done(input logic [63:0] v);
    logic [63:0] d;
    int li, j;
    logic [31:0] id;
    case (phase)
      S_PROFILE: begin profile = v[7:0]; enter(S_SKIP16); end
      S_SKIP16: enter(S_SPSID);
      S_SPSID: begin
        if (profile >= 100) begin high_seen = 1; enter(S_CHROMA); end
        else enter(S_LOG2FN);
      end
      S_CHROMA: enter(v == 3 ? S_SEPCOL : S_BDL);
      S_SEPCOL: enter(S_BDL);
      S_BDL: enter(S_BDC);
      S_BDC: enter(S_BYPASS);
      S_BYPASS: enter(S_SMP);
      S_SMP: begin
        if (v != 0) begin loop_cnt = 0; enter(S_SLP); end
        else enter(S_LOG2FN);
      end
      S_SLP: begin
        if (v != 0) begin
          scale = 8; loop_cnt = loop_cnt & 9'h1C0; enter(S_DELTA);
        end else next_scaling_list();
      end
      S_DELTA: begin
        d = v[0] ? (v >> 1) + 1 : 64'd0 - (v >> 1);
        li = loop_cnt[8:6];
        j = loop_cnt[5:0] + 1;
        scale = scale + d[7:0];
        if (scale == 0 || j >= (li < 6 ? 16 : 64)) next_scaling_list();
        else begin
          loop_cnt = {li[2:0], j[5:0]};
          enter(S_DELTA);
        end
      end
      S_LOG2FN: begin fn_bits = len_cap(v); enter(S_POCTYPE); end
      S_POCTYPE: begin
        poc_mode = (v > 6) ? 6 : int'(v);
        if (v == 0) enter(S_LOG2POC);
        else if (v == 1) enter(S_DPOAZ);
        else enter(S_NUMREF);
      end
      S_LOG2POC: begin poc_bits = len_cap(v); enter(S_NUMREF); end
      S_DPOAZ: enter(S_OFFNR);
      S_OFFNR: enter(S_OFFTB);
      S_OFFTB: enter(S_NCYCLE);
      S_NCYCLE: begin
        loop_cnt = (v > POC_CYCLE_CAP) ? 9'(POC_CYCLE_CAP) : v[8:0];
        enter(loop_cnt != 0 ? S_CYCOFF : S_NUMREF);
      end
      S_CYCOFF: begin
        loop_cnt = loop_cnt - 1;
        enter(loop_cnt != 0 ? S_CYCOFF : S_NUMREF);
      end
      S_NUMREF: enter(S_GAPS);
      S_GAPS: enter(S_WIDTH);
      S_WIDTH: begin width_px = dim_cap(16 * (v + 1)); enter(S_HEIGHT); end
      S_HEIGHT: begin enter(S_FMO); acc = v + 1; end  // map units kept for fmo
      L_FIRSTMB: enter(L_TYPE);
      L_TYPE: begin
        if (v == 2 || v == 7 || v == 4 || v == 9)
          key = (cur_kind == KIND_IDR) || (high_seen && cur_kind == KIND_SLICE);
        else if (v <= 9) key = 0;
        enter(L_PPSID);
      end
      L_PPSID: enter(L_FRAMENUM);
      L_FRAMENUM: begin
        if (v[31:0] != last_fn) start = 1;
        last_fn = v[31:0];
        if (cur_kind == KIND_IDR) enter(L_IDR);
        else if (poc_mode == 0) enter(L_POC);
        else enter(PH_IDLE);
      end
      L_IDR: begin
        id = (v > 64'h1FFFE) ? 32'h1FFFE : v[31:0];
        if (prev_kind == KIND_IDR && last_idr != id) start = 1;
        last_idr = id;
        enter(poc_mode == 0 ? L_POC : PH_IDLE);
      end
      L_POC: begin
        if (v[31:0] != last_poc) start = 1;
        last_poc = v[31:0];
        enter(PH_IDLE);
      end
      default: enter(PH_IDLE);
    endcase
  endfunction

  function automatic void shift_bit(input bit b);
    logic [63:0] h;
    int w;
    if (phase == PH_IDLE) return;
    if (phase == S_FMO) begin
      h = acc * 32;
      if (b) h = h >> 1;
      height_px = dim_cap(h);
      enter(PH_IDLE);
      return;
    end
    w = phase_width(phase);
    if (w > 0) begin
      acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
      lz++;
      if (lz >= w) field_done(acc);
    end else if (acc == 0) begin
      if (!b) begin
        lz++;
        if (lz >= CODE_BITS) field_done((64'd1 << CODE_BITS) - 1);
      end else if (lz == 0) field_done(0);
      else acc = 1;
    end else begin
      acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
      lz--;
      if (lz == 0) field_done(acc - 1);
    end
    // zero-width fields finish without consuming bits
    while (phase != PH_IDLE && phase_width(phase) == 0) field_done(0);
  endfunction

  // returns 1 when the byte finishes a unit, with its summary in r
  function automatic bit predict_unit_byte(input logic [7:0] b, input bit last,
                                           output haud_out_t r);
    r = '0;
    if (hdr_pending) begin
      hdr_pending = 0; zrun = 0;
      cur_kind = b[4:0]; cur_ref = b[6:5];
      start = (cur_kind == KIND_SPS || cur_kind == KIND_PPS);
      if (cur_kind == KIND_SPS) enter(S_PROFILE);
      else if (cur_kind >= KIND_SLICE && cur_kind <= KIND_IDR) enter(L_FIRSTMB);
      else enter(PH_IDLE);
    end else if (zrun == 2 && b == 8'h03) begin
      zrun = 0;  // emulation prevention byte dropped
    end else begin
      for (int k = 7; k >= 0; k--) shift_bit(b[k]);
      zrun = (b == 0) ? ((zrun >= 2) ? 2 : zrun + 1) : 0;
    end
    if (!last) return 0;
    while (phase != PH_IDLE) shift_bit(0);  // truncated unit reads zeros
    r.starts_access_unit = start;
    r.key_picture = key;
    r.unit_kind = cur_kind;
    r.reference_level = cur_ref;
    r.picture_width = width_px[13:0];
    r.picture_height = height_px[13:0];
    prev_kind = cur_kind;
    hdr_pending = 1;
    zrun = 0;
    return 1;
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit last);
    haud_out_t r;
    in_data <= '{unit_byte: b, unit_end: last};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_unit_byte(b, last, r)) unit_summary_q.push_back(r);
    items_sent++;
    // each following cycle idles with the set chance
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send_unit(input logic [7:0] hdr, input logic [7:0] body[$]);
    send_byte(hdr, body.size() == 0);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
  endtask

  // rbsp bits of the unit under construction
  bit rbsp_q[$];

  function automatic void put_bits(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) rbsp_q.push_back(v[i]);
  endfunction

  function automatic void put_ue(input logic [63:0] v);
    logic [63:0] c;
    int n;
    c = v + 1;
    n = 0;
    while ((c >> n) > 1) n++;
    put_bits(0, n);
    put_bits(c, n + 1);
  endfunction

  // packs the bits, mostly with a stop bit, adds random trailing bytes and emulation prevention, then sends
  task automatic send_rbsp(input logic [7:0] hdr, input int extra_bytes);
    logic [7:0] body[$];
    logic [7:0] b;
    int z;
    z = 0;
    if ($urandom_range(3) != 0) rbsp_q.push_back(1);
    while (rbsp_q.size() % 8 != 0) rbsp_q.push_back(0);
    repeat (extra_bytes * 8) rbsp_q.push_back($urandom_range(1));
    while (rbsp_q.size() > 0) begin
      for (int i = 0; i < 8; i++) b[7 - i] = rbsp_q.pop_front();
      if (z == 2 && b <= 3) begin body.push_back(8'h03); z = 0; end
      body.push_back(b);
      z = (b == 0) ? ((z >= 2) ? 2 : z + 1) : 0;
    end
    send_unit(hdr, body);
  endtask

  function automatic logic [7:0] header(input logic [4:0] kind);
    return {1'($urandom_range(1)), 2'($urandom_range(3)), kind};
  endfunction

  // well-formed sequence parameter set with random content
  task automatic send_sps(input bit high, input int poc_sel);
    logic [7:0] sc;
    logic [63:0] v, d;
    int size, ncyc;
    rbsp_q.delete();
    put_bits(high ? $urandom_range(100, 255) : $urandom_range(0, 99), 8);
    put_bits($urandom, 16);
    put_ue($urandom_range(31));
    if (high) begin
      v = $urandom_range(3);
      put_ue(v);
      if (v == 3) put_bits($urandom_range(1), 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      v = $urandom_range(1);
      put_bits(v, 1);
      if (v) begin
        for (int li = 0; li < 8; li++) begin
          v = $urandom_range(1);
          put_bits(v, 1);
          if (v) begin
            sc = 8;
            size = li < 6 ? 16 : 64;
            for (int j = 0; j < size; j++) begin
              v = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(8);
              put_ue(v);
              d = v[0] ? (v >> 1) + 1 : 64'd0 - (v >> 1);
              sc = sc + d[7:0];
              if (sc == 0) break;
            end
          end
        end
      end
    end
    put_ue($urandom_range(9) == 0 ? $urandom_range(13, 100) : $urandom_range(12));
    put_ue(poc_sel);
    if (poc_sel == 0)
      put_ue($urandom_range(9) == 0 ? $urandom_range(13, 100) : $urandom_range(12));
    else if (poc_sel == 1) begin
      put_bits($urandom_range(1), 1);
      put_ue($urandom_range(20));
      put_ue($urandom_range(20));
      ncyc = $urandom_range(15) == 0 ? $urandom_range(250, 300) : $urandom_range(4);
      put_ue(ncyc);
      repeat (ncyc) put_ue($urandom_range(20));
    end
    put_ue($urandom_range(16));
    put_bits($urandom_range(1), 1);
    put_ue($urandom_range(9) == 0 ? $urandom_range(500, 100000) : $urandom_range(120));
    put_ue($urandom_range(9) == 0 ? $urandom_range(300, 100000) : $urandom_range(70));
    put_bits($urandom_range(1), 1);
    send_rbsp(header(KIND_SPS), $urandom_range(2));
  endtask

  // well-formed slice header; reuses stored values often so that some
  // slices continue the current access unit
  task automatic send_slice(input logic [4:0] kind);
    bit same;
    same = $urandom_range(1);
    rbsp_q.delete();
    put_ue($urandom_range(3) == 0 ? $urandom_range(8000) : 0);
    put_ue($urandom_range(15) == 0 ? $urandom_range(10, 40) : $urandom_range(9));
    put_ue($urandom_range(3));
    put_bits(same ? last_fn : $urandom, fn_bits);
    if (kind == KIND_IDR)
      put_ue(same ? 64'(last_idr) :
             ($urandom_range(7) == 0 ? $urandom_range(131000, 200000)
                                     : $urandom_range(3)));
    if (poc_mode == 0) put_bits(same ? last_poc : $urandom, poc_bits);
    send_rbsp(header(kind), $urandom_range(3));
  endtask

  // random bytes under a random header, zeros favored
  task automatic send_noise_unit();
    logic [7:0] body[$];
    repeat ($urandom_range(6))
      body.push_back($urandom_range(2) == 0 ? 8'h00 :
                     ($urandom_range(3) == 0 ? 8'h03 : 8'($urandom)));
    send_unit(8'($urandom), body);
  endtask

  task automatic wait_for_drain();
    in_valid <= 0;
    @(posedge clk);
    while (unit_summary_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver, checking and watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    haud_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (unit_summary_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = unit_summary_q.pop_front();
        if (out_data.starts_access_unit != want.starts_access_unit)
          report_mismatch("starts_access_unit", out_data.starts_access_unit,
                          want.starts_access_unit);
        if (out_data.key_picture != want.key_picture)
          report_mismatch("key_picture", out_data.key_picture, want.key_picture);
        if (out_data.unit_kind != want.unit_kind)
          report_mismatch("unit_kind", out_data.unit_kind, want.unit_kind);
        if (out_data.reference_level != want.reference_level)
          report_mismatch("reference_level", out_data.reference_level,
                          want.reference_level);
        if (out_data.picture_width != want.picture_width)
          report_mismatch("picture_width", out_data.picture_width, want.picture_width);
        if (out_data.picture_height != want.picture_height)
          report_mismatch("picture_height", out_data.picture_height,
                          want.picture_height);
      end
    end
  end

  // nothing accepted on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    logic [7:0] body[$];
    // header-only units at the kind extremes and a pps, then a slice before any sps
    send_unit(8'h00, body);
    send_unit(8'hFF, body);
    send_unit({1'b0, 2'd3, KIND_PPS}, body);
    send_slice(KIND_SLICE);
    // baseline sps, poc type 0, then slices against it
    send_sps(0, 0);
    send_slice(KIND_IDR);
    send_slice(KIND_IDR);
    send_slice(KIND_SLICE);
    // high profile with scaling lists, poc type 1 with cycle offsets
    send_sps(1, 1);
    send_slice(KIND_SLICE);
    send_slice(5'd3);
    // exp-golomb code with 32 leading zeros
    body = {8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF};
    send_unit({1'b0, 2'd1, KIND_IDR}, body);
    // emulation byte as the last byte of a unit
    body = {8'h00, 8'h00, 8'h03};
    send_unit({1'b0, 2'd2, KIND_SLICE}, body);
    // sps cut short after the profile byte
    body = {8'hFF};
    send_unit({1'b0, 2'd3, KIND_SPS}, body);
    send_sps(0, 2);
    send_slice(5'd2);
    send_slice(5'd4);
  endtask

  task automatic test_random();
    int pick;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 15) send_sps($urandom_range(1), $urandom_range(9) == 0 ? 7 : $urandom_range(2));
      else if (pick < 22) send_unit(header(KIND_PPS), {8'($urandom)});
      else if (pick < 80)
        send_slice($urandom_range(3) == 0 ? KIND_IDR : 5'($urandom_range(1, 4)));
      else send_noise_unit();
    end
  endtask

  // stretch with no idling on either side
  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (20) send_slice($urandom_range(1) ? KIND_SLICE : KIND_IDR);
    tx_idle_pct = 38;
    rx_idle_pct = 38;
  endtask

  // receiver holds off while the sender keeps offering, then the sender
  // pauses until every summary has come back
  task automatic test_backpressure();
    rx_hold_req = 3000;
    repeat (40) send_slice(KIND_SLICE);
    wait_for_drain();
  endtask

  initial begin
    parser_reset();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();
    wait_for_drain();
    repeat (200) @(posedge clk);
    if (unit_summary_q.size() != 0) report_mismatch("missing items", 0, unit_summary_q.size());
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[h264_access_unit_detector_unit.f]
design/haud_pkg.sv
design/haud_bit_parser.sv
design/h264_access_unit_detector_unit.sv
tb/sv/h264_access_unit_detector_unit_tb.sv
